// ----- sv/sequential_list_engine_defines.svh -----
// Assertion helpers shared by the list engine RTL.
// Both expect clk and rst_n in scope.
`ifndef SEQUENTIAL_LIST_ENGINE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define SLE_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sle assertion failed");

// Next-cycle implication.
`define SLE_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sle assertion failed");

`endif

// ----- sv/sle_pkg.sv -----
`timescale 1ns / 1ps
package sle_pkg;

    typedef enum logic [3:0] {
        OP_DUMP        = 4'd0,
        OP_INIT        = 4'd1,
        OP_INSERT_AT   = 4'd2,
        OP_INSERT_HEAD = 4'd3,
        OP_INSERT_TAIL = 4'd4,
        OP_SEARCH      = 4'd5,
        OP_DEL_HEAD    = 4'd6,
        OP_DEL_TAIL    = 4'd7,
        OP_DEL_AT      = 4'd8,
        OP_DEL_VALUE   = 4'd9,
        OP_CLEAR       = 4'd10,
        OP_DESTROY     = 4'd11
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOINIT   = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_BADPOS   = 3'd4,
        ST_NOTFOUND = 3'd5
    } status_t;

    typedef struct packed {
        logic [3:0]         operation;
        logic [6:0]         position;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] element;
        logic [6:0]         where;
        logic [6:0]         match_count;
        logic [6:0]         list_length;
        logic               last;
    } out_word_t;

    // result word offered by the sequencer to the output register
    typedef struct packed {
        logic      valid;
        out_word_t word;
    } res_t;

endpackage

// ----- sv/sle_ram.sv -----
`timescale 1ns / 1ps
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds while rd_en is low
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/sle_seq.sv -----
`timescale 1ns / 1ps
`include "sequential_list_engine_defines.svh"
module sle_seq #(
    parameter int CAPACITY = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  sle_pkg::in_word_t           req,
    output sle_pkg::res_t               res,
    input  logic                        res_ready,
    output logic                        wr_en,
    output logic [$clog2(CAPACITY)-1:0] wr_addr,
    output logic [31:0]                 wr_data,
    output logic                        rd_en,
    output logic [$clog2(CAPACITY)-1:0] rd_addr,
    input  logic [31:0]                 rd_data
);
    import sle_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_SCAN,
        S_SHUP,
        S_SHDN
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           flag_reg, flag_next;
    logic           pend_reg, pend_next;
    logic           more_reg, more_next;
    logic           hold_valid_reg, hold_valid_next;
    logic [CW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]  n_reg, n_next;

    logic [3:0]     op_reg, op_next;
    logic [31:0]    val_reg, val_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]  end_reg, end_next;
    logic [AW-1:0]  p1_reg, p1_next;
    logic [AW-1:0]  hold_pos_reg, hold_pos_next;
    logic [2:0]     status_reg, status_next;
    logic [6:0]     where_reg, where_next;
    logic [6:0]     mc_reg, mc_next;

    logic [AW-1:0]  ins_idx, del_idx, count_last;
    logic           is_full, pos_bad, consume, descend, hit;

    assign req_ready  = (state_reg == S_IDLE);
    assign is_full    = (count_reg == CW'(CAPACITY));
    assign pos_bad    = (req.position == 7'd0) || (req.position > 7'(count_reg));
    assign count_last = AW'(count_reg - CW'(1));
    assign hit        = (rd_data == val_reg);
    assign descend    = (state_reg == S_SHUP);

    always_comb
    begin
        ins_idx = AW'(count_reg);
        if (req.operation == OP_INSERT_AT)
        begin
            ins_idx = AW'(req.position - 7'd1);
        end
        else if (req.operation == OP_INSERT_HEAD)
        begin
            ins_idx = '0;
        end
        del_idx = AW'(req.position - 7'd1);
        if (req.operation == OP_DEL_HEAD)
        begin
            del_idx = '0;
        end
        else if (req.operation == OP_DEL_TAIL)
        begin
            del_idx = count_last;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        flag_next       = flag_reg;
        pend_next       = pend_reg;
        more_next       = more_reg;
        hold_valid_next = hold_valid_reg;
        wr_ptr_next     = wr_ptr_reg;
        n_next          = n_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        idx_next        = idx_reg;
        rd_ptr_next     = rd_ptr_reg;
        end_next        = end_reg;
        p1_next         = p1_reg;
        hold_pos_next   = hold_pos_reg;
        status_next     = status_reg;
        where_next      = where_reg;
        mc_next         = mc_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = rd_ptr_reg;
        res             = '0;
        consume         = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req.operation;
                    val_next    = req.value;
                    status_next = ST_OK;
                    where_next  = '0;
                    mc_next     = '0;
                    state_next  = S_RESP;
                    pend_next   = 1'b0;
                    more_next   = 1'b1;
                    rd_ptr_next = '0;
                    end_next    = count_last;
                    n_next      = '0;
                    wr_ptr_next = '0;
                    hold_valid_next = 1'b0;
                    case (req.operation)
                        OP_INIT:
                        begin
                            flag_next  = 1'b1;
                            count_next = '0;
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_DESTROY:
                        begin
                            flag_next  = 1'b0;
                            count_next = '0;
                        end
                        OP_DUMP, OP_SEARCH, OP_DEL_VALUE:
                        begin
                            if (!flag_reg)
                            begin
                                status_next = ST_NOINIT;
                            end
                            else if (count_reg == '0)
                            begin
                                if (req.operation == OP_DEL_VALUE)
                                begin
                                    status_next = ST_NOTFOUND;
                                end
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_INSERT_AT, OP_INSERT_HEAD, OP_INSERT_TAIL:
                        begin
                            if (!flag_reg)
                            begin
                                status_next = ST_NOINIT;
                            end
                            else if (req.operation == OP_INSERT_AT && count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (req.operation == OP_INSERT_AT && pos_bad)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else if (CW'(ins_idx) == count_reg)
                            begin
                                // nothing to move: write in place
                                wr_en      = 1'b1;
                                wr_addr    = ins_idx;
                                wr_data    = req.value;
                                count_next = CW'(count_reg + CW'(1));
                            end
                            else
                            begin
                                idx_next    = ins_idx;
                                rd_ptr_next = count_last;
                                end_next    = ins_idx;
                                state_next  = S_SHUP;
                            end
                        end
                        OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_AT:
                        begin
                            if (!flag_reg)
                            begin
                                status_next = ST_NOINIT;
                            end
                            else if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (req.operation == OP_DEL_AT && pos_bad)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else if (del_idx == count_last)
                            begin
                                count_next = CW'(count_reg - CW'(1));
                            end
                            else
                            begin
                                rd_ptr_next = AW'(del_idx + AW'(1));
                                state_next  = S_SHDN;
                            end
                        end
                        default:
                        begin
                            // unused codes answer ok and change nothing
                        end
                    endcase
                end
            end

            S_RESP:
            begin
                res.valid            = 1'b1;
                res.word.status      = status_reg;
                res.word.where       = where_reg;
                res.word.match_count = mc_reg;
                res.word.list_length = 7'(count_reg);
                res.word.last        = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                // stage 1: data of entry p1 is on rd_data
                if (pend_reg)
                begin
                    case (state_reg)
                        S_SHUP:
                        begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(p1_reg + AW'(1));
                            wr_data = rd_data;
                        end
                        S_SHDN:
                        begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(p1_reg - AW'(1));
                            wr_data = rd_data;
                        end
                        default:
                        begin
                            if (op_reg == OP_DUMP)
                            begin
                                res.valid            = 1'b1;
                                res.word.element     = rd_data;
                                res.word.where       = 7'(p1_reg) + 7'd1;
                                res.word.list_length = 7'(count_reg);
                                res.word.last        = (7'(p1_reg) + 7'd1 == 7'(count_reg));
                                consume              = res_ready;
                            end
                            else if (op_reg == OP_SEARCH)
                            begin
                                // a match is held back until the next one shows
                                // whether it is the last
                                if (hit && hold_valid_reg)
                                begin
                                    res.valid            = 1'b1;
                                    res.word.where       = 7'(hold_pos_reg) + 7'd1;
                                    res.word.list_length = 7'(count_reg);
                                    consume              = res_ready;
                                end
                                if (consume && hit)
                                begin
                                    hold_valid_next = 1'b1;
                                    hold_pos_next   = p1_reg;
                                    n_next          = CW'(n_reg + CW'(1));
                                end
                            end
                            else
                            begin
                                if (hit)
                                begin
                                    n_next = CW'(n_reg + CW'(1));
                                end
                                else
                                begin
                                    wr_en       = 1'b1;
                                    wr_addr     = wr_ptr_reg[AW-1:0];
                                    wr_data     = rd_data;
                                    wr_ptr_next = CW'(wr_ptr_reg + CW'(1));
                                end
                            end
                        end
                    endcase
                end

                // stage 0: issue the next read
                if (!pend_reg || consume)
                begin
                    if (more_reg)
                    begin
                        rd_en     = 1'b1;
                        pend_next = 1'b1;
                        p1_next   = rd_ptr_reg;
                        if (rd_ptr_reg == end_reg)
                        begin
                            more_next = 1'b0;
                        end
                        else if (descend)
                        begin
                            rd_ptr_next = AW'(rd_ptr_reg - AW'(1));
                        end
                        else
                        begin
                            rd_ptr_next = AW'(rd_ptr_reg + AW'(1));
                        end
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                end

                // walk finished
                if (!pend_reg && !more_reg)
                begin
                    state_next = S_RESP;
                    case (state_reg)
                        S_SHUP:
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = idx_reg;
                            wr_data    = val_reg;
                            count_next = CW'(count_reg + CW'(1));
                        end
                        S_SHDN:
                        begin
                            count_next = CW'(count_reg - CW'(1));
                        end
                        default:
                        begin
                            if (op_reg == OP_DUMP)
                            begin
                                state_next = S_IDLE;
                            end
                            else if (op_reg == OP_SEARCH)
                            begin
                                where_next = hold_valid_reg ? 7'(hold_pos_reg) + 7'd1 : 7'd0;
                                mc_next    = 7'(n_reg);
                            end
                            else
                            begin
                                count_next  = wr_ptr_reg;
                                mc_next     = 7'(n_reg);
                                status_next = (n_reg != '0) ? ST_OK : ST_NOTFOUND;
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            flag_reg       <= 1'b0;
            pend_reg       <= 1'b0;
            more_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            n_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            flag_reg       <= flag_next;
            pend_reg       <= pend_next;
            more_reg       <= more_next;
            hold_valid_reg <= hold_valid_next;
            wr_ptr_reg     <= wr_ptr_next;
            n_reg          <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        rd_ptr_reg   <= rd_ptr_next;
        end_reg      <= end_next;
        p1_reg       <= p1_next;
        hold_pos_reg <= hold_pos_next;
        status_reg   <= status_next;
        where_reg    <= where_next;
        mc_reg       <= mc_next;
    end

    `SLE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY))
    `SLE_ASSERT_NOW(a_no_rw_collide, wr_en && rd_en, wr_addr != rd_addr)
    `SLE_ASSERT_NOW(a_noinit_empty, !flag_reg, count_reg == '0)
    `SLE_ASSERT_NEXT(a_accept_busy, req_valid && req_ready, !req_ready)

endmodule

// ----- sv/sequential_list_engine.sv -----
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed 32-bit words held in one RAM.
// req channel (req_valid/req_ready, payload req): one word per operation.
// rsp channel (rsp_valid/rsp_ready, payload rsp): one or more words per
// operation; the final one has last set. Dump gives one word per entry,
// search one per match with the match count on the last.
// One operation is in flight at a time; req_ready is high only while idle.
// Status-only ops and in-place insert/delete read no entry; insert/delete
// with shift walk the entries that move; dump, search and delete-by-value
// walk all n entries, n being the current length.
// The walk reads one RAM entry per cycle while the receiver does not stall.
// A registered output stage lets the result wait while the engine runs on;
// when the receiver stalls, the RAM walk holds and resumes without loss.
// Reset: list not initialized, length 0; RAM contents are not cleared,
// entries beyond the length are never read.
module sequential_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  sle_pkg::in_word_t  req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output sle_pkg::out_word_t rsp
);
    import sle_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    res_t          res;
    logic          res_ready;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [31:0]   wr_data, rd_data;
    logic          rsp_valid_reg;
    out_word_t     rsp_reg;

    assign res_ready = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    sle_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sle_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res       (res),
        .res_ready (res_ready),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            rsp_reg <= res.word;
        end
    end

endmodule
